>>> design/lkvc_pkg.sv
package lkvc_pkg;

    // Widths fixed by the item and register formats.
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int CAP_W       = 5;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int ENTRIES_DEF = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Register byte addresses.
    localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = APB_ADDR_W'(0);

    // Operation codes carried in the input tuser.
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } t_state;

    // Update command broadcast to every cell.
    typedef struct packed {
        logic en;       // apply this update
        logic wr_key;   // selected cell takes a new key and becomes valid
        logic wr_val;   // selected cell takes a new value
        logic age_all;  // every valid unselected cell ages by one
    } t_upd;

    // Lookup data handed from one cell to the next.
    typedef struct packed {
        logic               free_seen;  // an invalid cell lies further up the chain
        logic               hit;        // a matching cell lies further up the chain
        logic [VALUE_W-1:0] value;      // value of the matching cell, else zero
    } t_chain;

endpackage

>>> design/lkvc_cell.sv
module lkvc_cell #(
    parameter int RANK_W = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [lkvc_pkg::KEY_W-1:0]   i_key,
    input  logic [lkvc_pkg::VALUE_W-1:0] i_value,
    input  lkvc_pkg::t_upd        i_upd,
    input  logic                  i_sel,
    input  logic [RANK_W-1:0]     i_old_rank,
    input  logic [RANK_W-1:0]     i_lru_rank,
    input  lkvc_pkg::t_chain      i_chain,
    input  logic [RANK_W-1:0]     i_rank_chain,
    output lkvc_pkg::t_chain      o_chain,
    output logic [RANK_W-1:0]     o_rank_chain,
    output logic                  o_match,
    output logic                  o_lru,
    output logic                  o_first_free,
    output logic                  o_valid
);
    import lkvc_pkg::*;

    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_value;
    logic               r_valid;
    logic [RANK_W-1:0]  r_rank;

    always_comb begin
        o_match      = r_valid && (r_key == i_key);
        o_lru        = r_valid && (r_rank == i_lru_rank);
        o_first_free = !r_valid && !i_chain.free_seen;
        o_valid      = r_valid;

        o_chain.free_seen = i_chain.free_seen || !r_valid;
        o_chain.hit       = i_chain.hit || o_match;
        o_chain.value     = i_chain.value | (o_match ? r_value : '0);
        o_rank_chain      = i_rank_chain | (o_match ? r_rank : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd.en) begin
            if (i_sel) begin
                r_rank <= '0;
                if (i_upd.wr_key) begin
                    r_valid <= 1'b1;
                end
            end else if (r_valid && (i_upd.age_all || (r_rank < i_old_rank))) begin
                r_rank <= RANK_W'(r_rank + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en && i_sel) begin
            if (i_upd.wr_key) begin
                r_key <= i_key;
            end
            if (i_upd.wr_val) begin
                r_value <= i_value;
            end
        end
    end

endmodule

>>> design/lru_key_value_cache_core.sv
// Fully associative key/value cache with least-recently-used replacement, built as a row
// of ENTRIES identical cells. Each input transaction is a get (tuser = 0) or a put
// (tuser = 1) with a 32-bit key and a 32-bit value in tdata; each produces exactly one
// output transaction carrying the hit flag in tuser and the read value in tdata (the
// stored value on a get hit, zero on a get miss and on every put). An item passes through
// a lookup state, in which every cell compares its key and the match, the first free
// cell and the matching value ripple along the chain, and then an update state, in which
// the chosen cell, if any, is written and the other cells age their recency ranks. A new
// transaction is accepted during the update state. The item register lets the next item
// enter while a result still waits; its lookup then repeats until the waiting result is
// taken. The capacity register (byte address 0) limits the number of valid entries; zero
// acts as one and values above ENTRIES act as ENTRIES. Lowering it below the current
// occupancy drops nothing; later put misses then replace the least recent entry. The
// register should be written only while the cache is idle. No clearing pass is needed
// after reset.
module lru_key_value_cache_core #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
    input  logic        s_tuser,   // [0] kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] read_value
    output logic        m_tuser,   // [0] hit

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lkvc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lkvc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lkvc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import lkvc_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    // Configuration register.
    logic [CAP_W-1:0] r_cap;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAPACITY) ? APB_DATA_W'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    // Control and item registers.
    t_state             r_state, n_state;
    logic               r_kind;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_value;
    logic [OCC_W-1:0]   r_occ;
    logic [ENTRIES-1:0] r_sel;
    logic [RANK_W-1:0]  r_old_rank;
    t_upd               r_upd;
    logic               r_m_valid;
    logic               r_m_hit;
    logic [VALUE_W-1:0] r_m_value;

    // Cell chain.
    t_chain             w_chain      [ENTRIES+1];
    logic [RANK_W-1:0]  w_rank_chain [ENTRIES+1];
    logic [ENTRIES-1:0] w_match, w_lru, w_free, w_valid;
    logic [RANK_W-1:0]  w_lru_rank;
    t_upd               w_upd;

    assign w_chain[0]      = '{free_seen: 1'b0, hit: 1'b0, value: '0};
    assign w_rank_chain[0] = '0;
    assign w_lru_rank      = RANK_W'(r_occ - 1'b1);
    // The update command is live only in the update cycle.
    assign w_upd           = (r_state == ST_UPD) ? r_upd : '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkvc_cell #(.RANK_W(RANK_W)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_key        (r_key),
            .i_value      (r_value),
            .i_upd        (w_upd),
            .i_sel        (r_sel[g]),
            .i_old_rank   (r_old_rank),
            .i_lru_rank   (w_lru_rank),
            .i_chain      (w_chain[g]),
            .i_rank_chain (w_rank_chain[g]),
            .o_chain      (w_chain[g+1]),
            .o_rank_chain (w_rank_chain[g+1]),
            .o_match      (w_match[g]),
            .o_lru        (w_lru[g]),
            .o_first_free (w_free[g]),
            .o_valid      (w_valid[g])
        );
    end

    // Effective capacity and the full test.
    logic [CMP_W-1:0] w_eff_cap;
    logic             w_full;
    logic             w_hit;

    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(ENTRIES)) begin
            w_eff_cap = CMP_W'(ENTRIES);
        end else begin
            w_eff_cap = CMP_W'(r_cap);
        end
        w_full = CMP_W'(r_occ) >= w_eff_cap;
        w_hit  = w_chain[ENTRIES].hit;
    end

    // Handshake. The lookup completes only when the output register is free or is
    // being emptied in the same cycle; until then the lookup cycle repeats.
    logic w_in_acc;
    logic w_look_go;

    assign s_tready  = (r_state == ST_IDLE) || (r_state == ST_UPD);
    assign w_in_acc  = s_tvalid && s_tready;
    assign w_look_go = (r_state == ST_LOOK) && (!r_m_valid || m_tready);
    assign m_tvalid  = r_m_valid;
    assign m_tuser   = r_m_hit;
    assign m_tdata   = r_m_value;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: n_state = w_in_acc ? ST_LOOK : ST_IDLE;
            ST_LOOK: n_state = w_look_go ? ST_UPD : ST_LOOK;
            ST_UPD:  n_state = w_in_acc ? ST_LOOK : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_occ     <= '0;
            r_upd     <= '0;
        end else begin
            r_state <= n_state;

            if (w_look_go) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end

            if (w_look_go) begin
                // A hit promotes the entry; a put miss replaces the least recent
                // entry when full, otherwise fills the first free cell.
                r_upd.en      <= w_hit || (r_kind == KIND_PUT);
                r_upd.wr_key  <= !w_hit && (r_kind == KIND_PUT);
                r_upd.wr_val  <= r_kind == KIND_PUT;
                r_upd.age_all <= !w_hit && (r_kind == KIND_PUT) && !w_full;
            end

            if ((r_state == ST_UPD) && r_upd.age_all) begin
                r_occ <= OCC_W'(r_occ + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind  <= s_tuser;
            r_key   <= s_tdata[KEY_W-1:0];
            r_value <= s_tdata[KEY_W +: VALUE_W];
        end
        if (w_look_go) begin
            r_m_hit   <= w_hit;
            r_m_value <= (r_kind == KIND_GET) ? w_chain[ENTRIES].value : '0;
            if (w_hit) begin
                r_sel      <= w_match;
                r_old_rank <= w_rank_chain[ENTRIES];
            end else if (r_kind == KIND_PUT && w_full) begin
                r_sel      <= w_lru;
                r_old_rank <= w_lru_rank;
            end else if (r_kind == KIND_PUT) begin
                r_sel      <= w_free;
                r_old_rank <= '0;
            end else begin
                r_sel      <= '0;
                r_old_rank <= '0;
            end
        end
    end

    // The occupancy counter tracks the number of valid cells.
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_occ))
        else $error("occupancy does not match valid cells");

    // An update touches at most one cell.
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> $onehot0(r_sel))
        else $error("more than one cell selected");

    // A lookup finds at most one matching key.
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("duplicate key in cache");

    // An update that is applied always selects a cell.
    a_put_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && r_upd.en) |-> (r_sel != '0))
        else $error("update without target cell");

endmodule
